// ----- hdl/kmeans_color_quantizer_top_macros.svh -----
// assertion macros used by the sequencing state machine of the k-means color quantizer
`ifndef KMEANS_COLOR_QUANTIZER_TOP_MACROS_SVH
`define KMEANS_COLOR_QUANTIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KCQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KCQ_ASSERT_SAME(label, ante, cons, msg)
`define KCQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hdl/kcq_pkg.sv -----
// shared constants, types and functions of the k-means color quantizer
`default_nettype none
package kcq_pkg;

    localparam int NUM_CENTROIDS = 16;
    localparam int MAX_PIXELS    = 65536;
    localparam int REPORT_MAX    = 16;
    localparam int REPORT_N      = (NUM_CENTROIDS < REPORT_MAX) ? NUM_CENTROIDS : REPORT_MAX;
    localparam int CEN_W         = $clog2(NUM_CENTROIDS);
    localparam int PIX_AW        = $clog2(MAX_PIXELS);
    localparam int CNT_W         = PIX_AW + 1;
    localparam int SUM_W         = PIX_AW + 8;
    localparam int DIST_W        = 18;
    localparam int ROOT_W        = DIST_W + 1;
    localparam int ITER_W        = 8;
    localparam logic [ITER_W-1:0] ITER_RESET = 8'd100;

    localparam logic KIND_CENTROID = 1'b0;
    localparam logic KIND_LABEL    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD_PIXEL    = 2'd0,
        OP_LOAD_CENTROID = 2'd1,
        OP_RUN           = 2'd2,
        OP_READ_LABEL    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_OUT,
        ST_PASS_CHECK,
        ST_PASS_START,
        ST_ASSIGN,
        ST_DRAIN,
        ST_UPD_LOAD,
        ST_UPD_DIV,
        ST_UPD_WRITE,
        ST_PASS_END,
        ST_REPORT
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [3:0]  centroid_slot;
        logic [15:0] pixel_address;
        logic        clear_pixels;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [3:0] cluster_index;
        logic [7:0] passes_done;
        logic       converged;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load_pixel;
        logic load_centroid;
        logic run_begin;
        logic read_issue;
        logic read_load;
        logic pass_start;
        logic issue;
        logic div_load;
        logic div_step;
        logic upd_write;
        logic set_conv;
        logic report_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_more;
        logic pipe_busy;
        logic cnt_zero;
        logic div_last;
        logic cj_last;
        logic rep_last;
        logic changed;
        logic at_limit;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [DIST_W-1:0] rem;
        logic [ROOT_W-1:0] res;
    } root_t;

    // one digit of the bitwise integer square root, digit weight 4**k
    function automatic root_t sqrt_step(input root_t s, input int k);
        logic [ROOT_W-1:0] b;
        logic [ROOT_W-1:0] t;
        root_t             r;
        b = ROOT_W'(1) << (2 * k);
        t = s.res + b;
        r = s;
        if ({1'b0, s.rem} >= t) begin
            r.rem = s.rem - DIST_W'(t);
            r.res = (s.res >> 1) + b;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/kcq_stream_if.sv -----
// request and response channel interfaces of the k-means color quantizer
`default_nettype none
interface kcq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [3:0]  centroid_slot;
    logic [15:0] pixel_address;
    logic        clear_pixels;

    modport source (
        output valid, operation, blue, green, red, centroid_slot, pixel_address,
               clear_pixels,
        input  ready
    );
    modport sink (
        input  valid, operation, blue, green, red, centroid_slot, pixel_address,
               clear_pixels,
        output ready
    );
endinterface

interface kcq_rsp_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [3:0] cluster_index;
    logic [7:0] passes_done;
    logic       converged;
    logic       last;

    modport source (
        output valid, result_kind, out_blue, out_green, out_red, cluster_index,
               passes_done, converged, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, out_blue, out_green, out_red, cluster_index,
               passes_done, converged, last,
        output ready
    );
endinterface
`default_nettype wire

// ----- hdl/kcq_ctrl.sv -----
// sequencing state machine of the k-means color quantizer
`default_nettype none
`include "kmeans_color_quantizer_top_macros.svh"
module kcq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         in_op,
    output logic                    in_ready,
    output kcq_pkg::ctrl_cmd_t      cmd,
    input  wire kcq_pkg::dp_status_t status
);

    kcq_pkg::ctrl_state_t state_reg;
    kcq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= kcq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            kcq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (kcq_pkg::op_t'(in_op))
                        kcq_pkg::OP_LOAD_PIXEL:    cmd.load_pixel = 1'b1;
                        kcq_pkg::OP_LOAD_CENTROID: cmd.load_centroid = 1'b1;
                        kcq_pkg::OP_RUN:
                        begin
                            cmd.run_begin = 1'b1;
                            state_next    = kcq_pkg::ST_PASS_CHECK;
                        end
                        kcq_pkg::OP_READ_LABEL:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = kcq_pkg::ST_READ_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            kcq_pkg::ST_READ_OUT:
            begin
                if (status.out_free) begin
                    cmd.read_load = 1'b1;
                    state_next    = kcq_pkg::ST_IDLE;
                end
            end
            kcq_pkg::ST_PASS_CHECK:
            begin
                state_next = status.at_limit ? kcq_pkg::ST_REPORT : kcq_pkg::ST_PASS_START;
            end
            kcq_pkg::ST_PASS_START:
            begin
                cmd.pass_start = 1'b1;
                state_next     = kcq_pkg::ST_ASSIGN;
            end
            kcq_pkg::ST_ASSIGN:
            begin
                if (status.issue_more) begin
                    cmd.issue = 1'b1;
                end else begin
                    state_next = kcq_pkg::ST_DRAIN;
                end
            end
            kcq_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy) begin
                    state_next = kcq_pkg::ST_UPD_LOAD;
                end
            end
            kcq_pkg::ST_UPD_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = status.cnt_zero ? kcq_pkg::ST_UPD_WRITE : kcq_pkg::ST_UPD_DIV;
            end
            kcq_pkg::ST_UPD_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = kcq_pkg::ST_UPD_WRITE;
                end
            end
            kcq_pkg::ST_UPD_WRITE:
            begin
                cmd.upd_write = 1'b1;
                state_next    = status.cj_last ? kcq_pkg::ST_PASS_END : kcq_pkg::ST_UPD_LOAD;
            end
            kcq_pkg::ST_PASS_END:
            begin
                if (!status.changed) begin
                    cmd.set_conv = 1'b1;
                    state_next   = kcq_pkg::ST_REPORT;
                end else begin
                    state_next = kcq_pkg::ST_PASS_CHECK;
                end
            end
            kcq_pkg::ST_REPORT:
            begin
                if (status.out_free) begin
                    cmd.report_load = 1'b1;
                    if (status.rep_last) begin
                        state_next = kcq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = kcq_pkg::ST_IDLE;
            end
        endcase
    end

    // new transactions only once the distance pipeline has emptied
    `KCQ_ASSERT_SAME(a_ready_pipe_empty, in_ready, !status.pipe_busy, "accept while pipeline busy")
    `KCQ_ASSERT_NEXT(a_report_ends, (state_reg == kcq_pkg::ST_REPORT) && status.out_free && status.rep_last, state_reg == kcq_pkg::ST_IDLE, "report did not end after last centroid")
    `KCQ_ASSERT_SAME(a_no_zero_divide, cmd.div_step, !status.cnt_zero, "mean divide on empty cluster")

endmodule
`default_nettype wire

// ----- hdl/kcq_datapath.sv -----
// storage, distance pipeline, accumulators and mean dividers of the quantizer
`default_nettype none
module kcq_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    input  wire kcq_pkg::in_item_t    in_item,
    input  wire kcq_pkg::ctrl_cmd_t   cmd,
    output kcq_pkg::dp_status_t       status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output kcq_pkg::out_item_t        out_item
);

    localparam int N = kcq_pkg::NUM_CENTROIDS;

    typedef struct packed {
        logic [kcq_pkg::CEN_W-1:0]  j;
        logic [kcq_pkg::PIX_AW-1:0] idx;
        logic                       last;
    } issue_tag_t;

    typedef struct packed {
        issue_tag_t  id;
        logic [23:0] pix;
    } pipe_tag_t;

    // configuration and run state
    logic [kcq_pkg::ITER_W-1:0] limit_reg;
    logic [kcq_pkg::ITER_W-1:0] pass_reg;
    logic                       conv_reg;
    logic                       changed_reg;
    logic [kcq_pkg::CNT_W-1:0]  pixel_count_reg;
    logic [kcq_pkg::CNT_W-1:0]  pix_idx_reg;
    logic [kcq_pkg::CEN_W-1:0]  cj_reg;
    logic [kcq_pkg::CEN_W-1:0]  cj_next;

    // memories
    logic [23:0]               pix_mem [kcq_pkg::MAX_PIXELS];
    logic [23:0]               pix_rd_reg;
    logic [kcq_pkg::CEN_W-1:0] lbl_mem [kcq_pkg::MAX_PIXELS];
    logic [kcq_pkg::CEN_W-1:0] lbl_rd_reg;
    logic                      addr_ok_reg;
    logic [23:0]               cen_reg [N];

    // distance pipeline
    logic                      a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg;
    issue_tag_t                a_tag_reg;
    pipe_tag_t                 b_tag_reg, c_tag_reg, d_tag_reg, e_tag_reg, f_tag_reg;
    logic [15:0]               sq_b_reg [3];
    logic [kcq_pkg::DIST_W-1:0] dist_c_reg;
    kcq_pkg::root_t            root_d_reg, root_e_reg, root_f_reg;
    logic [8:0]                best_root_reg;
    logic [kcq_pkg::CEN_W-1:0] best_idx_reg;

    // accumulators and dividers
    logic [kcq_pkg::SUM_W-1:0] b_sum_reg [N];
    logic [kcq_pkg::SUM_W-1:0] g_sum_reg [N];
    logic [kcq_pkg::SUM_W-1:0] r_sum_reg [N];
    logic [kcq_pkg::CNT_W-1:0] cnt_reg [N];
    logic [kcq_pkg::SUM_W-1:0] rem_reg [3];
    logic [7:0]                quo_reg [3];
    logic [kcq_pkg::CNT_W-1:0] divisor_reg;
    logic [2:0]                step_reg;

    logic                      out_valid_reg;
    kcq_pkg::out_item_t        out_reg;

    // combinational
    logic [23:0]               color_in;
    logic [kcq_pkg::CNT_W-1:0] load_base;
    logic                      load_ok;
    logic [31:0]               addr_ext;
    logic [kcq_pkg::CEN_W-1:0] cen_rd_idx;
    logic [23:0]               cen_rd;
    logic [15:0]               sq_a [3];
    kcq_pkg::root_t            root_d_in, root_e_in, root_f_in;
    logic [8:0]                root_val;
    logic                      take;
    logic [kcq_pkg::CEN_W-1:0] win_idx;
    logic [kcq_pkg::CEN_W-1:0] acc_idx;
    logic                      acc_en;
    logic [kcq_pkg::SUM_W-1:0] trial;
    logic [23:0]               new_cen;
    logic                      out_free;

    assign color_in  = {in_item.red, in_item.green, in_item.blue};
    assign load_base = in_item.clear_pixels ? '0 : pixel_count_reg;
    assign load_ok   = load_base < kcq_pkg::CNT_W'(kcq_pkg::MAX_PIXELS);
    assign addr_ext  = 32'(in_item.pixel_address);
    assign cj_next   = (cj_reg == kcq_pkg::CEN_W'(N - 1)) ? '0 : cj_reg + 1'b1;

    // single centroid read port: pipeline stage a while busy, else the shared counter
    assign cen_rd_idx = a_v_reg ? a_tag_reg.j : cj_reg;
    assign cen_rd     = cen_reg[cen_rd_idx];

    always_comb
    begin
        logic [7:0] pa;
        logic [7:0] pc;
        logic [7:0] d;
        for (int k = 0; k < 3; k++) begin
            pa      = pix_rd_reg[8*k +: 8];
            pc      = cen_rd[8*k +: 8];
            d       = (pa > pc) ? pa - pc : pc - pa;
            sq_a[k] = {8'd0, d} * {8'd0, d};
        end
    end

    always_comb
    begin
        root_d_in.rem = dist_c_reg;
        root_d_in.res = '0;
        for (int k = 0; k < 3; k++) begin
            root_d_in = kcq_pkg::sqrt_step(root_d_in, 8 - k);
        end
        root_e_in = root_d_reg;
        for (int k = 0; k < 3; k++) begin
            root_e_in = kcq_pkg::sqrt_step(root_e_in, 5 - k);
        end
        root_f_in = root_e_reg;
        for (int k = 0; k < 3; k++) begin
            root_f_in = kcq_pkg::sqrt_step(root_f_in, 2 - k);
        end
    end

    // running minimum; strict less-than keeps the lower index on a tie
    assign root_val = root_f_reg.res[8:0];
    assign take     = (f_tag_reg.id.j == '0) || (root_val < best_root_reg);
    assign win_idx  = take ? f_tag_reg.id.j : best_idx_reg;
    assign acc_en   = f_v_reg && f_tag_reg.id.last;
    assign acc_idx  = f_v_reg ? win_idx : cj_reg;
    assign trial    = kcq_pkg::SUM_W'(divisor_reg) << step_reg;
    assign new_cen  = {quo_reg[2], quo_reg[1], quo_reg[0]};
    assign out_free = !out_valid_reg || out_ready;

    assign status.issue_more = pix_idx_reg < pixel_count_reg;
    assign status.pipe_busy  = a_v_reg | b_v_reg | c_v_reg | d_v_reg | e_v_reg | f_v_reg;
    assign status.cnt_zero   = cnt_reg[acc_idx] == '0;
    assign status.div_last   = step_reg == '0;
    assign status.cj_last    = cj_reg == kcq_pkg::CEN_W'(N - 1);
    assign status.rep_last   = cj_reg == kcq_pkg::CEN_W'(kcq_pkg::REPORT_N - 1);
    assign status.changed    = changed_reg;
    assign status.at_limit   = pass_reg >= limit_reg;
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg       <= kcq_pkg::ITER_RESET;
            pass_reg        <= '0;
            conv_reg        <= 1'b0;
            changed_reg     <= 1'b0;
            pixel_count_reg <= '0;
            pix_idx_reg     <= '0;
            cj_reg          <= '0;
            a_v_reg         <= 1'b0;
            b_v_reg         <= 1'b0;
            c_v_reg         <= 1'b0;
            d_v_reg         <= 1'b0;
            e_v_reg         <= 1'b0;
            f_v_reg         <= 1'b0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.load_pixel && load_ok) begin
                pixel_count_reg <= load_base + 1'b1;
            end
            if (cmd.run_begin) begin
                pass_reg <= '0;
                conv_reg <= 1'b0;
            end
            if (cmd.set_conv) begin
                conv_reg <= 1'b1;
            end
            if (cmd.pass_start) begin
                pass_reg    <= pass_reg + 1'b1;
                changed_reg <= 1'b0;
            end else if (cmd.upd_write && !status.cnt_zero && (new_cen != cen_rd)) begin
                changed_reg <= 1'b1;
            end
            if (cmd.pass_start) begin
                pix_idx_reg <= '0;
            end else if (cmd.issue && status.cj_last) begin
                pix_idx_reg <= pix_idx_reg + 1'b1;
            end
            if (cmd.run_begin || cmd.pass_start) begin
                cj_reg <= '0;
            end else if (cmd.issue || cmd.upd_write || cmd.report_load) begin
                cj_reg <= cj_next;
            end
            a_v_reg <= cmd.issue;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            if (cmd.div_load) begin
                step_reg <= 3'd7;
            end else if (cmd.div_step) begin
                step_reg <= step_reg - 1'b1;
            end
            if (cmd.read_load || cmd.report_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working sums, cleared at the start of every pass
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < N; k++) begin
                b_sum_reg[k] <= '0;
                g_sum_reg[k] <= '0;
                r_sum_reg[k] <= '0;
                cnt_reg[k]   <= '0;
            end
        end else if (cmd.pass_start) begin
            for (int k = 0; k < N; k++) begin
                b_sum_reg[k] <= '0;
                g_sum_reg[k] <= '0;
                r_sum_reg[k] <= '0;
                cnt_reg[k]   <= '0;
            end
        end else if (acc_en) begin
            b_sum_reg[acc_idx] <= b_sum_reg[acc_idx] + kcq_pkg::SUM_W'(f_tag_reg.pix[7:0]);
            g_sum_reg[acc_idx] <= g_sum_reg[acc_idx] + kcq_pkg::SUM_W'(f_tag_reg.pix[15:8]);
            r_sum_reg[acc_idx] <= r_sum_reg[acc_idx] + kcq_pkg::SUM_W'(f_tag_reg.pix[23:16]);
            cnt_reg[acc_idx]   <= cnt_reg[acc_idx] + 1'b1;
        end
    end

    // pixel memory
    always_ff @(posedge clk) begin
        if (cmd.load_pixel && load_ok) begin
            pix_mem[load_base[kcq_pkg::PIX_AW-1:0]] <= color_in;
        end
        pix_rd_reg <= pix_mem[pix_idx_reg[kcq_pkg::PIX_AW-1:0]];
    end

    // label memory
    always_ff @(posedge clk) begin
        if (acc_en) begin
            lbl_mem[f_tag_reg.id.idx] <= win_idx;
        end
        if (cmd.read_issue) begin
            lbl_rd_reg  <= lbl_mem[addr_ext[kcq_pkg::PIX_AW-1:0]];
            addr_ok_reg <= addr_ext < 32'(kcq_pkg::MAX_PIXELS);
        end
    end

    // centroid registers
    always_ff @(posedge clk) begin
        if (cmd.load_centroid && (32'(in_item.centroid_slot) < 32'(N))) begin
            cen_reg[kcq_pkg::CEN_W'(in_item.centroid_slot)] <= color_in;
        end else if (cmd.upd_write && !status.cnt_zero) begin
            cen_reg[cj_reg] <= new_cen;
        end
    end

    // pipeline payload, best match and divider datapath
    always_ff @(posedge clk) begin
        if (cmd.issue) begin
            a_tag_reg.j    <= cj_reg;
            a_tag_reg.idx  <= pix_idx_reg[kcq_pkg::PIX_AW-1:0];
            a_tag_reg.last <= status.cj_last;
        end
        b_tag_reg.id  <= a_tag_reg;
        b_tag_reg.pix <= pix_rd_reg;
        for (int k = 0; k < 3; k++) begin
            sq_b_reg[k] <= sq_a[k];
        end
        c_tag_reg  <= b_tag_reg;
        dist_c_reg <= kcq_pkg::DIST_W'(sq_b_reg[0]) + kcq_pkg::DIST_W'(sq_b_reg[1])
                    + kcq_pkg::DIST_W'(sq_b_reg[2]);
        d_tag_reg  <= c_tag_reg;
        root_d_reg <= root_d_in;
        e_tag_reg  <= d_tag_reg;
        root_e_reg <= root_e_in;
        f_tag_reg  <= e_tag_reg;
        root_f_reg <= root_f_in;
        if (f_v_reg) begin
            best_root_reg <= take ? root_val : best_root_reg;
            best_idx_reg  <= win_idx;
        end
        if (cmd.div_load) begin
            rem_reg[0]  <= b_sum_reg[acc_idx];
            rem_reg[1]  <= g_sum_reg[acc_idx];
            rem_reg[2]  <= r_sum_reg[acc_idx];
            divisor_reg <= cnt_reg[acc_idx];
            for (int k = 0; k < 3; k++) begin
                quo_reg[k] <= '0;
            end
        end else if (cmd.div_step) begin
            // restoring divide, one quotient bit per cycle; the mean fits a byte
            for (int k = 0; k < 3; k++) begin
                if (rem_reg[k] >= trial) begin
                    rem_reg[k]           <= rem_reg[k] - trial;
                    quo_reg[k][step_reg] <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk) begin
        if (cmd.read_load) begin
            out_reg.result_kind   <= kcq_pkg::KIND_LABEL;
            out_reg.out_blue      <= '0;
            out_reg.out_green     <= '0;
            out_reg.out_red       <= '0;
            out_reg.cluster_index <= addr_ok_reg ? 4'(lbl_rd_reg) : 4'd0;
            out_reg.passes_done   <= pass_reg;
            out_reg.converged     <= 1'b0;
            out_reg.last          <= 1'b1;
        end else if (cmd.report_load) begin
            out_reg.result_kind   <= kcq_pkg::KIND_CENTROID;
            out_reg.out_blue      <= cen_rd[7:0];
            out_reg.out_green     <= cen_rd[15:8];
            out_reg.out_red       <= cen_rd[23:16];
            out_reg.cluster_index <= 4'(cj_reg);
            out_reg.passes_done   <= pass_reg;
            out_reg.converged     <= conv_reg;
            out_reg.last          <= status.rep_last;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/kmeans_color_quantizer_top.sv -----
// K-means color quantizer with 16 centroids over up to 65536 stored pixels. Pixel and
// centroid loads are accepted back to back; a label read is registered from the label
// memory and then loaded into the output register once it is free. A run is timed by the
// single distance unit, which scores one pixel against one centroid per cycle; a pass
// scores every loaded pixel against every centroid, then the serial mean dividers update
// each non-empty centroid, and the run ends with 16 report transactions. No new request
// is taken until a run or read has handed its last result to the output register.
`default_nettype none
module kmeans_color_quantizer_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    kcq_req_if.sink     req,
    kcq_rsp_if.source   rsp
);

    kcq_pkg::in_item_t   in_item;
    kcq_pkg::out_item_t  out_item;
    kcq_pkg::ctrl_cmd_t  cmd;
    kcq_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;

    assign in_item.operation     = req.operation;
    assign in_item.blue          = req.blue;
    assign in_item.green         = req.green;
    assign in_item.red           = req.red;
    assign in_item.centroid_slot = req.centroid_slot;
    assign in_item.pixel_address = req.pixel_address;
    assign in_item.clear_pixels  = req.clear_pixels;
    assign req.ready             = in_ready;

    kcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.operation),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    kcq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (rsp.ready),
        .out_item    (out_item)
    );

    assign rsp.valid         = out_valid;
    assign rsp.result_kind   = out_item.result_kind;
    assign rsp.out_blue      = out_item.out_blue;
    assign rsp.out_green     = out_item.out_green;
    assign rsp.out_red       = out_item.out_red;
    assign rsp.cluster_index = out_item.cluster_index;
    assign rsp.passes_done   = out_item.passes_done;
    assign rsp.converged     = out_item.converged;
    assign rsp.last          = out_item.last;

endmodule
`default_nettype wire
